// File: rtl/lwe_bit_decrypt_packer_macros.svh
// Assertion macros for the LWE bit decrypt packer.
// No dependencies; included by the top level only.
`ifndef LWE_BIT_DECRYPT_PACKER_MACROS_SVH
`define LWE_BIT_DECRYPT_PACKER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define LBDP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication, disabled during reset.
`define LBDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define LBDP_ASSERT_NOW(label, clk, rst, ante, cons)
`define LBDP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/lbdp_pkg.sv
// Shared types and constants for the LWE bit decrypt packer.
// No dependencies; imported by the top level and the decode stage.
package lbdp_pkg;

  localparam int CMD_W   = 2;
  localparam int INDEX_W = 5;
  localparam int DATA_W  = 20;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCUM  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

  // Control that travels down the pipeline beside each word.
  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] command;
    logic             idx_ok;
  } ctl_t;

endpackage

// File: rtl/lbdp_modred.sv
// Three-stage reduction modulo a constant by reciprocal multiply and correction.
// No dependencies; instantiated twice by the top level.
module lbdp_modred #(
  parameter int IN_W    = 20,
  parameter int MODULUS = 2000,
  parameter int MW      = 11
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IN_W-1:0] x,
  output logic [MW-1:0]   r
);

  localparam longint unsigned RECIP = (64'd1 << IN_W) / MODULUS;
  localparam int RW = $clog2(RECIP + 1);
  localparam int PW = IN_W + RW;
  localparam int QW = RW + MW + 1;
  localparam logic [RW-1:0]   RECIP_C = RW'(RECIP);
  localparam logic [MW:0]     MOD_C   = (MW + 1)'(MODULUS);
  localparam logic [IN_W-1:0] M1      = IN_W'(MODULUS);
  localparam logic [IN_W-1:0] M2      = IN_W'(2 * MODULUS);

  logic [IN_W-1:0] x1;
  logic [IN_W-1:0] x2;
  logic [PW-1:0]   p1;
  logic [IN_W-1:0] qm2;
  logic [RW-1:0]   q_est;
  logic [QW-1:0]   qm_full;
  logic [IN_W-1:0] rem;
  logic [MW-1:0]   r_next;

  // Quotient estimate falls short by at most one, so the remainder is below 2*MODULUS.
  assign q_est   = RW'(p1 >> IN_W);
  assign qm_full = QW'(q_est) * QW'(MOD_C);
  assign rem     = x2 - qm2;

  always_comb begin
    priority if (rem >= M2) begin
      r_next = MW'(rem - M2);
    end else if (rem >= M1) begin
      r_next = MW'(rem - M1);
    end else begin
      r_next = MW'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= x;
      p1  <= PW'(x) * PW'(RECIP_C);
      x2  <= x1;
      qm2 <= IN_W'(qm_full);
      r   <= r_next;
    end
  end

endmodule

// File: rtl/lbdp_secret_mem.sv
// Secret coefficient store: one write port, one registered read port.
// No dependencies; instantiated by the top level.
module lbdp_secret_mem #(
  parameter int DEPTH = 30,
  parameter int AW    = 5,
  parameter int MW    = 11
) (
  input  logic          clk,
  input  logic          en,
  input  logic          wr_en,
  input  logic [AW-1:0] addr,
  input  logic [MW-1:0] wr_data,
  output logic [MW-1:0] rd_data
);

  logic [MW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en && wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // Hold the read data while the pipeline is frozen.
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// File: rtl/lbdp_accum_decode.sv
// Running sum, threshold decode, byte packer and result register.
// Depends on lbdp_pkg for the control struct and command codes.
module lbdp_accum_decode import lbdp_pkg::*; #(
  parameter int MODULUS = 2000,
  parameter int MW      = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  ctl_t          ctl,
  input  logic [MW-1:0] prod_red,
  input  logic [MW-1:0] tail,
  input  logic          result_ready,
  output logic          result_valid,
  output logic          plain_bit,
  output logic          byte_complete,
  output logic [7:0]    message_byte
);

  localparam logic [MW:0] MOD_C    = (MW + 1)'(MODULUS);
  localparam logic [MW:0] LO_C     = (MW + 1)'(MODULUS / 4);
  localparam logic [MW:0] HI_C     = (MW + 1)'((3 * MODULUS) / 4);
  localparam logic [2:0]  LAST_BIT = 3'd7;

  logic [MW-1:0] sum;
  logic [MW:0]   acc_raw;
  logic [MW-1:0] sum_add;
  logic [MW:0]   diff_raw;
  logic [MW:0]   diff;
  logic          bit_dec;
  logic [2:0]    bit_count;
  logic [7:0]    byte_shift;
  logic [7:0]    shift_next;
  logic          last_bit;
  logic          is_acc;
  logic          is_fin;

  assign is_acc = ctl.valid && (ctl.command == CMD_ACCUM) && ctl.idx_ok;
  assign is_fin = ctl.valid && (ctl.command == CMD_FINISH);

  assign acc_raw = {1'b0, sum} + {1'b0, prod_red};
  assign sum_add = (acc_raw >= MOD_C) ? MW'(acc_raw - MOD_C) : acc_raw[MW-1:0];

  // Wrap a negative difference back into range.
  assign diff_raw = {1'b0, tail} - {1'b0, sum};
  assign diff     = diff_raw[MW] ? (diff_raw + MOD_C) : diff_raw;
  assign bit_dec  = (diff > LO_C) && (diff < HI_C);

  assign shift_next = {byte_shift[6:0], bit_dec};
  assign last_bit   = (bit_count == LAST_BIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum          <= '0;
      bit_count    <= '0;
      byte_shift   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (en && is_acc) begin
        sum <= sum_add;
      end else if (en && is_fin) begin
        sum <= '0;
      end
      if (en && is_fin) begin
        bit_count    <= bit_count + 3'd1;
        byte_shift   <= last_bit ? 8'd0 : shift_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && is_fin) begin
      plain_bit     <= bit_dec;
      byte_complete <= last_bit;
      message_byte  <= last_bit ? shift_next : 8'd0;
    end
  end

endmodule

// File: rtl/lwe_bit_decrypt_packer.sv
// Top level of the LWE bit decrypt packer: pipeline control and assembly.
// Depends on lbdp_pkg, lbdp_modred, lbdp_secret_mem, lbdp_accum_decode and
// lwe_bit_decrypt_packer_macros.svh.
//
// Usage:
//   Input channel (valid/ready): one command word per handshake carrying
//   command, index and data_value. Load writes a secret coefficient,
//   accumulate adds secret[index] * data_value into the running sum mod
//   MODULUS, finish decodes one message bit from the column tail value.
//   Output channel (result_valid/result_ready): one word per finish command,
//   with plain_bit, byte_complete and message_byte (zero unless complete).
//   Throughput: unless frozen, one command word per cycle; every stage takes a
//   new word each cycle, as the pipeline, nine register stages deep in places,
//   never loops. The secret memory is written and read in the same stage, so a
//   load followed at once by an accumulate of the same entry sees the value.
//   Stall: the output register parts the two sides. The pipeline freezes only
//   when a finish word reaches the last stage while the output register still
//   holds an untaken word; load and accumulate words keep flowing otherwise.
//   Reset: clears the pipeline valid bits, running sum, bit count and partial
//   byte. The secret store is not cleared; load an entry before using it.
`include "lwe_bit_decrypt_packer_macros.svh"
module lwe_bit_decrypt_packer import lbdp_pkg::*; #(
  parameter int DIMENSION = 30,
  parameter int MODULUS   = 2000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic [CMD_W-1:0]   command,
  input  logic [INDEX_W-1:0] index,
  input  logic [DATA_W-1:0]  data_value,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               plain_bit,
  output logic               byte_complete,
  output logic [7:0]         message_byte
);

  localparam int MW    = $clog2(MODULUS);
  localparam int PW    = 2 * MW;
  localparam int DEPTH = (DIMENSION < (2 ** INDEX_W)) ? DIMENSION : (2 ** INDEX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          en;
  ctl_t          ctl_in;
  ctl_t          ctl_q  [8];
  logic [AW-1:0] addr_q [3];
  logic [MW-1:0] red_data;
  logic [MW-1:0] secret_rd;
  logic [MW-1:0] data4;
  logic [PW-1:0] prod5;
  logic [MW-1:0] tail_q [4];
  logic [MW-1:0] prod_red;
  logic          mem_wr;

  // Freeze everything only when a finish word would overwrite a held result.
  assign en = !(result_valid && !result_ready && ctl_q[7].valid &&
                (ctl_q[7].command == CMD_FINISH));
  assign ready = en;

  assign ctl_in.valid   = valid;
  assign ctl_in.command = command;
  assign ctl_in.idx_ok  = (int'(index) < DIMENSION);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= ctl_in;
      for (int i = 1; i < 8; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // Payload path: address to the memory stage, reduced operand and tail onward.
  always_ff @(posedge clk) begin
    if (en) begin
      addr_q[0] <= index[AW-1:0];
      addr_q[1] <= addr_q[0];
      addr_q[2] <= addr_q[1];
      data4     <= red_data;
      prod5     <= PW'(secret_rd) * PW'(data4);
      tail_q[0] <= data4;
      for (int i = 1; i < 4; i++) begin
        tail_q[i] <= tail_q[i-1];
      end
    end
  end

  // Reduce the incoming operand; ready at the memory stage.
  lbdp_modred #(
    .IN_W    (DATA_W),
    .MODULUS (MODULUS),
    .MW      (MW)
  ) u_data_red (
    .clk (clk),
    .en  (en),
    .x   (data_value),
    .r   (red_data)
  );

  assign mem_wr = ctl_q[2].valid && (ctl_q[2].command == CMD_LOAD) && ctl_q[2].idx_ok;

  lbdp_secret_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .MW    (MW)
  ) u_secret (
    .clk     (clk),
    .en      (en),
    .wr_en   (mem_wr),
    .addr    (addr_q[2]),
    .wr_data (red_data),
    .rd_data (secret_rd)
  );

  // Reduce the product; aligned with the last control stage.
  lbdp_modred #(
    .IN_W    (PW),
    .MODULUS (MODULUS),
    .MW      (MW)
  ) u_prod_red (
    .clk (clk),
    .en  (en),
    .x   (prod5),
    .r   (prod_red)
  );

  lbdp_accum_decode #(
    .MODULUS (MODULUS),
    .MW      (MW)
  ) u_decode (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .ctl           (ctl_q[7]),
    .prod_red      (prod_red),
    .tail          (tail_q[3]),
    .result_ready  (result_ready),
    .result_valid  (result_valid),
    .plain_bit     (plain_bit),
    .byte_complete (byte_complete),
    .message_byte  (message_byte)
  );

  // Input backpressure only comes from a held, untaken result.
  `LBDP_ASSERT_NOW(a_stall_cause, clk, rst, !ready, result_valid && !result_ready)
  // A stall keeps the held result visible next cycle.
  `LBDP_ASSERT_NEXT(a_stall_holds, clk, rst, !ready, result_valid)
  // A partial byte never leaks onto message_byte.
  `LBDP_ASSERT_NOW(a_byte_zero, clk, rst, result_valid && !byte_complete,
                   message_byte == 8'd0)
  // The completing bit is the low bit of the packed byte.
  `LBDP_ASSERT_NOW(a_byte_lsb, clk, rst, result_valid && byte_complete,
                   message_byte[0] == plain_bit)

endmodule
